[design/srfw_pkg.sv]
package srfw_pkg;

  localparam int unsigned ADDRESS_BITS_DEF = 16;
  localparam int unsigned DATA_BITS_DEF    = 8;

  localparam int unsigned ADDR_FIELD_W = 16;
  localparam int unsigned BYTE_FIELD_W = 8;

  // period_kind codes
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BIT   = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] DEV_EN_RESET = 2'b11;

  typedef struct packed {
    logic [ADDR_FIELD_W-1:0] reg_address;
    logic [BYTE_FIELD_W-1:0] byte_a;
    logic [BYTE_FIELD_W-1:0] byte_b;
    logic                    continue_burst;
    logic                    end_frame;
  } in_item_t;

  typedef struct packed {
    logic [1:0] period_kind;
    logic       pin_a;
    logic       pin_b;
    logic       latch_level;
    logic       last_of_run;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                    close_first;
    logic                    header;
    logic                    end_frame;
    logic [ADDR_FIELD_W-1:0] reg_address;
    logic [BYTE_FIELD_W-1:0] byte_a;
    logic [BYTE_FIELD_W-1:0] byte_b;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CLOSE,
    PH_START,
    PH_ADDR,
    PH_DATA,
    PH_END
  } phase_e;

endpackage

[design/srfw_front.sv]
module srfw_front import srfw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     push_o,
  output cmd_t     push_cmd_o,
  input  logic     q_ready_i
);

  logic frame_open_q, frame_open_d;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  always_comb begin
    push_cmd_o.close_first = frame_open_q && !in_data_i.continue_burst;
    // continue with no open frame opens a new one
    push_cmd_o.header      = !in_data_i.continue_burst || !frame_open_q;
    push_cmd_o.end_frame   = in_data_i.end_frame;
    push_cmd_o.reg_address = in_data_i.reg_address;
    push_cmd_o.byte_a      = in_data_i.byte_a;
    push_cmd_o.byte_b      = in_data_i.byte_b;
  end

  always_comb begin
    frame_open_d = frame_open_q;
    if (push_o) begin
      frame_open_d = !in_data_i.end_frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
    end else begin
      frame_open_q <= frame_open_d;
    end
  end

endmodule

[design/srfw_queue.sv]
module srfw_queue import srfw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 2'd2))
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != 2'd0))
    else $error("queue pop while empty");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count out of range");

endmodule

[design/srfw_back.sv]
module srfw_back import srfw_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF,
  parameter int unsigned DATA_BITS    = DATA_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] dev_en_i,
  input  logic       q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o
);

  localparam int unsigned MAX_BITS = (ADDRESS_BITS > DATA_BITS) ? ADDRESS_BITS : DATA_BITS;
  localparam int unsigned CNT_W    = $clog2(MAX_BITS + 1);
  localparam logic [CNT_W-1:0] ADDR_LAST = CNT_W'(ADDRESS_BITS - 1);
  localparam logic [CNT_W-1:0] DATA_LAST = CNT_W'(DATA_BITS - 1);

  phase_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  cmd_t             cmd_q, cmd_d;
  out_item_t        out_q, per;
  logic             out_vld_q;
  logic             advance, item_done, load;
  logic [31:0]      addr_sh, a_sh, b_sh;

  // bits above the field width shift out as zero
  assign addr_sh = 32'(cmd_q.reg_address) >> cnt_q;
  assign a_sh    = 32'(cmd_q.byte_a) >> cnt_q;
  assign b_sh    = 32'(cmd_q.byte_b) >> cnt_q;

  assign advance     = (state_q != PH_IDLE) && (!out_vld_q || out_ready_i);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign q_pop_o     = load;

  // period produced by the current phase
  always_comb begin
    per       = '0;
    item_done = 1'b0;
    case (state_q)
      PH_CLOSE: begin
        per.period_kind = KIND_END;
        per.latch_level = 1'b1;
      end
      PH_START: begin
        per.period_kind = KIND_START;
      end
      PH_ADDR: begin
        per.period_kind = KIND_BIT;
        per.pin_a       = addr_sh[0] & dev_en_i[0];
        per.pin_b       = addr_sh[0] & dev_en_i[1];
      end
      PH_DATA: begin
        per.period_kind = KIND_BIT;
        per.pin_a       = a_sh[0] & dev_en_i[0];
        per.pin_b       = b_sh[0] & dev_en_i[1];
        if ((cnt_q == '0) && !cmd_q.end_frame) begin
          item_done       = 1'b1;
          per.last_of_run = 1'b1;
        end
      end
      PH_END: begin
        per.period_kind = KIND_END;
        per.latch_level = 1'b1;
        per.last_of_run = 1'b1;
        item_done       = 1'b1;
      end
      default: begin
        per = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_d   = cmd_q;
    load    = 1'b0;
    if (state_q == PH_IDLE) begin
      load = q_valid_i;
    end else if (advance) begin
      case (state_q)
        PH_CLOSE: state_d = PH_START;
        PH_START: begin
          state_d = PH_ADDR;
          cnt_d   = ADDR_LAST;
        end
        PH_ADDR: begin
          if (cnt_q == '0) begin
            state_d = PH_DATA;
            cnt_d   = DATA_LAST;
          end else begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
        PH_DATA: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - CNT_W'(1);
          end else if (cmd_q.end_frame) begin
            state_d = PH_END;
          end
        end
        default: state_d = state_q;
      endcase
      if (item_done) begin
        if (q_valid_i) begin
          load = 1'b1;
        end else begin
          state_d = PH_IDLE;
        end
      end
    end
    if (load) begin
      cmd_d = q_cmd_i;
      cnt_d = DATA_LAST;
      if (q_cmd_i.close_first) begin
        state_d = PH_CLOSE;
      end else if (q_cmd_i.header) begin
        state_d = PH_START;
      end else begin
        state_d = PH_DATA;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    cmd_q <= cmd_d;
    if (advance) begin
      out_q <= per;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= PH_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  a_pop_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from empty queue");

  a_latch_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.latch_level == (out_q.period_kind == KIND_END)))
    else $error("latch level does not match period kind");

  a_close_has_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == PH_CLOSE) |-> cmd_q.header)
    else $error("close period without a new frame");

  a_hold_unsent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> (out_vld_q && $stable(out_q)))
    else $error("pending period overwritten");

endmodule

[design/serial_register_frame_writer_core.sv]
// Three-wire serial register writer for one or two devices sharing latch and
// clock. Each accepted request yields one result per serial period: DATA_BITS
// bit periods for a burst continuation, plus a start period and ADDRESS_BITS
// address periods when it opens a frame, plus one end period when it closes an
// open frame first and one when end_frame is set (8 to 27 periods at defaults).
// The back sequencer emits one period per cycle while the output is taken and
// loads the next queued request alongside the last period of the current one;
// starting from idle, it loads a request first. A two-entry request queue sits
// between the front classifier and the sequencer, so requests are accepted
// while earlier ones are still being serialized. device_enable is applied as
// each period is produced; write it only while the block is idle.
module serial_register_frame_writer_core import srfw_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF,
  parameter int unsigned DATA_BITS    = DATA_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  logic [1:0] dev_en_q;
  logic       push, q_ready, q_valid, q_pop;
  cmd_t       push_cmd, q_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_en_q <= DEV_EN_RESET;
    end else if (cfg_valid_i) begin
      dev_en_q <= cfg_data_i;
    end
  end

  srfw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .q_ready_i  (q_ready)
  );

  srfw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  srfw_back #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .DATA_BITS    (DATA_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dev_en_i    (dev_en_q),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
  import srfw_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_data = '0;

  serial_register_frame_writer_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  in_item_t  pending_reqs[$];
  out_item_t exp_periods[$];

  // predictor state
  logic [1:0] dev_en = DEV_EN_RESET;
  logic       frame_is_open = 1'b0;

  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_rx = 1'b0;
  event rx_hold_ev;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // serial periods caused by one request, in order
  function automatic void predict_periods(input in_item_t req);
    out_item_t run[27];
    int n;
    n = 0;
    if (!req.continue_burst || !frame_is_open) begin
      if (frame_is_open) begin
        run[n] = '{KIND_END, 1'b0, 1'b0, 1'b1, 1'b0};
        n++;
      end
      run[n] = '{KIND_START, 1'b0, 1'b0, 1'b0, 1'b0};
      n++;
      for (int i = ADDR_FIELD_W - 1; i >= 0; i--) begin
        run[n] = '{KIND_BIT, req.reg_address[i] & dev_en[0],
                   req.reg_address[i] & dev_en[1], 1'b0, 1'b0};
        n++;
      end
      frame_is_open = 1'b1;
    end
    for (int i = BYTE_FIELD_W - 1; i >= 0; i--) begin
      run[n] = '{KIND_BIT, req.byte_a[i] & dev_en[0], req.byte_b[i] & dev_en[1],
                 1'b0, 1'b0};
      n++;
    end
    if (req.end_frame) begin
      run[n] = '{KIND_END, 1'b0, 1'b0, 1'b1, 1'b0};
      n++;
      frame_is_open = 1'b0;
    end
    run[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) exp_periods.push_back(run[i]);
  endfunction

  // request driver
  always @(posedge clk) begin : drv
    logic     nxt_valid;
    in_item_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (rst_n) begin
      if (in_valid && in_ready) nxt_valid = 1'b0;
      if (!nxt_valid && pending_reqs.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt_data  = pending_reqs.pop_front();
        nxt_valid = 1'b1;
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  always @(posedge clk) begin : rx_drv
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off so the request queue fills and input stalls
  initial begin
    forever begin
      @(rx_hold_ev);
      @(posedge clk);
      hold_rx <= 1'b1;
      repeat (400) @(posedge clk);
      hold_rx <= 1'b0;
    end
  end

  always @(posedge clk) begin : mon
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) predict_periods(in_data);
      if (out_valid && out_ready) begin
        if (exp_periods.size() == 0) begin
          report_mismatch("unexpected period", int'(out_data), 0);
        end else begin
          want = exp_periods.pop_front();
          if (out_data.period_kind !== want.period_kind)
            report_mismatch("period_kind", int'(out_data.period_kind),
                            int'(want.period_kind));
          if (out_data.pin_a !== want.pin_a)
            report_mismatch("pin_a", int'(out_data.pin_a), int'(want.pin_a));
          if (out_data.pin_b !== want.pin_b)
            report_mismatch("pin_b", int'(out_data.pin_b), int'(want.pin_b));
          if (out_data.latch_level !== want.latch_level)
            report_mismatch("latch_level", int'(out_data.latch_level),
                            int'(want.latch_level));
          if (out_data.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", int'(out_data.last_of_run),
                            int'(want.last_of_run));
        end
      end
    end
  end

  function automatic in_item_t mk_req(input logic [15:0] addr, input logic [7:0] ba,
                                      input logic [7:0] bb, input logic cont,
                                      input logic endf);
    in_item_t r;
    r.reg_address    = addr;
    r.byte_a         = ba;
    r.byte_b         = bb;
    r.continue_burst = cont;
    r.end_frame      = endf;
    return r;
  endfunction

  task automatic write_dev_en(input logic [1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dev_en = val;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() > 0 || in_valid || exp_periods.size() > 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly well-formed frames with random content, some noise
  task automatic queue_frames(input int n_items);
    int left;
    int burst;
    in_item_t r;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(99) < 20) begin
        r = mk_req(16'($urandom), 8'($urandom), 8'($urandom),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
        pending_reqs.push_back(r);
        left--;
      end else begin
        burst = $urandom_range(4);
        for (int k = 0; k <= burst && left > 0; k++) begin
          r = mk_req(($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom),
                     8'($urandom), 8'($urandom), k != 0, 1'b0);
          if ($urandom_range(2) == 0) r.byte_b = r.byte_a;
          // occasionally leave the frame open so the next one closes it
          if (k == burst && $urandom_range(9) != 0) r.end_frame = 1'b1;
          pending_reqs.push_back(r);
          left--;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_dev_en(2'b11);
    // continue with no open frame opens one
    pending_reqs.push_back(mk_req(16'hFFFF, 8'hFF, 8'h00, 1'b1, 1'b0));
    pending_reqs.push_back(mk_req(16'h0000, 8'h00, 8'hFF, 1'b1, 1'b0));
    pending_reqs.push_back(mk_req(16'h1234, 8'hA5, 8'h5A, 1'b1, 1'b1));
    pending_reqs.push_back(mk_req(16'h0000, 8'h00, 8'h00, 1'b0, 1'b1));
    pending_reqs.push_back(mk_req(16'h8001, 8'hAA, 8'h55, 1'b0, 1'b0));
    // new frame while open: close period comes first
    pending_reqs.push_back(mk_req(16'h7FFE, 8'h3C, 8'h3C, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'hFFFF, 8'hFF, 8'hFF, 1'b0, 1'b1));
    pending_reqs.push_back(mk_req(16'hC3C3, 8'h81, 8'h7E, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'h0F0F, 8'h01, 8'h80, 1'b1, 1'b0));
    pending_reqs.push_back(mk_req(16'h0000, 8'hFF, 8'hFF, 1'b1, 1'b1));
    pending_reqs.push_back(mk_req(16'hFFFF, 8'h00, 8'h00, 1'b1, 1'b1));
    pending_reqs.push_back(mk_req(16'h5555, 8'h55, 8'hAA, 1'b0, 1'b0));
    wait_idle();

    write_dev_en(2'b01);
    pending_reqs.push_back(mk_req(16'hA5A5, 8'hFF, 8'hFF, 1'b0, 1'b1));
    queue_frames(90);
    wait_idle();

    write_dev_en(2'b10);
    send_idle_pct = 67;
    queue_frames(90);
    wait_idle();

    write_dev_en(2'b00);
    send_idle_pct  = 0;
    recv_stall_pct = 67;
    queue_frames(70);
    wait_idle();

    write_dev_en(2'b11);
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    queue_frames(60);
    -> rx_hold_ev;
    wait_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_frames(80);
    wait_idle();

    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
